// ===== rtl/core/lied_pkg.sv =====
// Shared types and constants for the label image erode/dilate pass.
`default_nettype none

package lied_pkg;

   localparam int CH_BITS       = 8;
   localparam int PIX_BITS      = 3 * CH_BITS;
   localparam int DIM_BITS      = 11;
   localparam int ROW_BITS      = 10;
   localparam int CFG_IDX_BITS  = 2;
   localparam int CFG_DATA_BITS = 11;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_LVL_BITS = 3;

   localparam logic [DIM_BITS-1:0] MAX_HEIGHT    = 11'd1024;
   localparam logic [DIM_BITS-1:0] RESET_WIDTH   = 11'd640;
   localparam logic [DIM_BITS-1:0] RESET_HEIGHT  = 11'd480;
   localparam logic [CH_BITS-1:0]  GRAY_LEVEL    = 8'd100;
   localparam logic [CH_BITS-1:0]  WHITE_LEVEL   = 8'd255;

   typedef enum logic {
      MODE_CONTRACT = 1'b0,
      MODE_EXPAND   = 1'b1
   } mode_type;

   typedef enum logic [CFG_IDX_BITS-1:0] {
      REG_PASS_MODE    = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } cfg_reg_type;

   // red sits in the low bits
   typedef struct packed {
      logic [CH_BITS-1:0] blue;
      logic [CH_BITS-1:0] green;
      logic [CH_BITS-1:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } fifo_push_type;

   localparam pixel_type GRAY_PIX  = '{blue: GRAY_LEVEL, green: GRAY_LEVEL, red: GRAY_LEVEL};
   localparam pixel_type WHITE_PIX =
      '{blue: WHITE_LEVEL, green: WHITE_LEVEL, red: WHITE_LEVEL};
   localparam pixel_type BLACK_PIX = '{blue: '0, green: '0, red: '0};

endpackage

`default_nettype wire

// ===== rtl/core/lied_ifs.sv =====
// Channel interfaces: pixel input, processed pixel output, register write.
`default_nettype none

interface lied_req_if;
   logic                        valid;
   logic                        ready;
   logic [lied_pkg::CH_BITS-1:0] red_in;
   logic [lied_pkg::CH_BITS-1:0] green_in;
   logic [lied_pkg::CH_BITS-1:0] blue_in;
   logic                        flush;

   modport source (output valid, red_in, green_in, blue_in, flush, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

interface lied_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lied_pkg::CH_BITS-1:0] red_out;
   logic [lied_pkg::CH_BITS-1:0] green_out;
   logic [lied_pkg::CH_BITS-1:0] blue_out;
   logic                        frame_last;

   modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

interface lied_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lied_pkg::CFG_IDX_BITS-1:0]  index;
   logic [lied_pkg::CFG_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/label_image_erode_dilate_pass.sv =====
// Erode/dilate pass over a raster RGB label image with a 4-neighbor cross window.
//
// req_if carries one raster pixel per word; flush words drain the frame end.
// A frame takes width*height pixel words and then width+1 drain words. A flush
// word that arrives before the frame's last pixel is taken and dropped.
// rsp_if returns one processed pixel per word in raster order; frame_last
// marks the final pixel. csr_if writes pass_mode (0), frame_width (1) and
// frame_height (2); any of these writes restarts the frame.
// Pixel (x, y) leaves on the word that enters one row plus one pixel later:
// the column read of the two line memories is registered, the window compare
// works on that read, and its result is registered into the result queue.
// Throughput is one word per clock while req_if ready is high: each word reads
// and rewrites a single column of both line memories, so one read and one
// write port per memory carry the full rate.
// A four-entry result queue takes results while rsp_if is stalled; req_if
// ready drops once the queue holds more than two results, and words in
// flight always find room.
// Reset selects contract mode at 640 x 480 and zeroes the frame counters.
// The line memories are not cleared: every neighbor read of a frame hits a
// column written earlier in that frame, so no clearing pass is needed.
`default_nettype none

module label_image_erode_dilate_pass #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lied_req_if.sink    req_if,
   lied_rsp_if.source  rsp_if,
   lied_csr_if.sink    csr_if
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WLIM_BITS = (COL_BITS + 1 > lied_pkg::DIM_BITS) ?
                              COL_BITS + 1 : lied_pkg::DIM_BITS;
   localparam logic [WLIM_BITS-1:0] WLIM_MAX = WLIM_BITS'(MAX_WIDTH);

   // configuration
   lied_pkg::mode_type                mode_ff;
   logic [lied_pkg::DIM_BITS-1:0]     width_ff;
   logic [lied_pkg::DIM_BITS-1:0]     height_ff;
   logic                              csr_write;
   lied_pkg::cfg_reg_type             csr_reg;
   logic                              restart;

   // frame position
   logic [COL_BITS-1:0]               in_col_ff, in_col_in;
   logic [lied_pkg::DIM_BITS-1:0]     in_row_ff, in_row_in;
   logic [COL_BITS-1:0]               out_col_ff, out_col_in;
   logic [lied_pkg::ROW_BITS-1:0]     out_row_ff, out_row_in;

   logic [WLIM_BITS-1:0]              w_ext, w_eff;
   logic [lied_pkg::DIM_BITS-1:0]     h_eff;
   logic                              pix_phase;
   logic                              accept;
   logic                              take;
   logic                              emit;
   logic                              col_wrap;
   logic                              has_up, has_down, has_left, has_right, last;
   lied_pkg::pixel_type               in_pix;

   // line memories: store_a holds the older row, store_b the newer
   lied_pkg::pixel_type               store_a [MAX_WIDTH];
   lied_pkg::pixel_type               store_b [MAX_WIDTH];
   lied_pkg::pixel_type               rd_a_ff, rd_b_ff;

   // window stage
   logic                              s1_valid_ff;
   logic [COL_BITS-1:0]               s1_col_ff;
   lied_pkg::pixel_type               s1_pix_ff;
   logic                              s1_emit_ff;
   logic                              s1_up_ff, s1_down_ff, s1_left_ff, s1_right_ff;
   logic                              s1_last_ff;
   logic                              fwd_ff;
   lied_pkg::pixel_type               fwd_a_ff, fwd_b_ff;
   lied_pkg::pixel_type               col_a, col_b;
   lied_pkg::pixel_type               p_up_ff, p_mid_ff, p_down_ff, pp_mid_ff;
   lied_pkg::pixel_type               border, nb_up, nb_down, nb_left, nb_right, center;
   lied_pkg::pixel_type               result;

   lied_pkg::fifo_push_type           push;
   logic [lied_pkg::FIFO_LVL_BITS-1:0] level;

   // ---------------------------------------------------------------- config

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;
   assign csr_reg      = lied_pkg::cfg_reg_type'(csr_if.index);

   always_comb begin
      restart = 1'b0;
      if (csr_write) begin
         unique case (csr_reg)
            lied_pkg::REG_PASS_MODE,
            lied_pkg::REG_FRAME_WIDTH,
            lied_pkg::REG_FRAME_HEIGHT: restart = 1'b1;
            default:                    restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= lied_pkg::MODE_CONTRACT;
         width_ff  <= lied_pkg::RESET_WIDTH;
         height_ff <= lied_pkg::RESET_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_reg)
            lied_pkg::REG_PASS_MODE:    mode_ff   <= lied_pkg::mode_type'(csr_if.data[0]);
            lied_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_if.data;
            lied_pkg::REG_FRAME_HEIGHT: height_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------ position tracking

   always_comb begin
      w_ext = WLIM_BITS'(width_ff);
      if (w_ext == '0) begin
         w_eff = WLIM_BITS'(1);
      end else if (w_ext > WLIM_MAX) begin
         w_eff = WLIM_MAX;
      end else begin
         w_eff = w_ext;
      end
      if (height_ff == '0) begin
         h_eff = lied_pkg::DIM_BITS'(1);
      end else if (height_ff > lied_pkg::MAX_HEIGHT) begin
         h_eff = lied_pkg::MAX_HEIGHT;
      end else begin
         h_eff = height_ff;
      end
   end

   assign req_if.ready = (level <= lied_pkg::FIFO_LVL_BITS'(lied_pkg::FIFO_DEPTH - 2));
   assign accept       = req_if.valid && req_if.ready;
   assign pix_phase    = (in_row_ff < h_eff);
   // early flush words are dropped without touching state
   assign take         = accept && !(req_if.flush && pix_phase);

   assign in_pix = pix_phase ?
                   lied_pkg::pixel_type'{blue: req_if.blue_in, green: req_if.green_in,
                                         red: req_if.red_in} :
                   lied_pkg::BLACK_PIX;

   assign col_wrap = (WLIM_BITS'(in_col_ff) + 1'b1) >= w_eff;
   // output starts once one row plus one pixel has entered
   assign emit     = (in_row_ff >= lied_pkg::DIM_BITS'(2)) ||
                     ((in_row_ff == lied_pkg::DIM_BITS'(1)) && (in_col_ff != '0));

   assign has_up    = (out_row_ff != '0);
   assign has_down  = (lied_pkg::DIM_BITS'(out_row_ff) + 1'b1) < h_eff;
   assign has_left  = (out_col_ff != '0);
   assign has_right = (WLIM_BITS'(out_col_ff) + 1'b1) < w_eff;
   assign last      = !has_down && !has_right;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (!has_right) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= take;
      end
   end

   // --------------------------------------------------------- column access

   always_ff @(posedge clock) begin
      if (take) begin
         rd_a_ff <= store_a[in_col_ff];
         rd_b_ff <= store_b[in_col_ff];
      end
   end

   // one-column frames reread the column written in the same cycle
   always_ff @(posedge clock) begin
      if (take) begin
         s1_col_ff   <= in_col_ff;
         s1_pix_ff   <= in_pix;
         s1_emit_ff  <= emit;
         s1_up_ff    <= has_up;
         s1_down_ff  <= has_down;
         s1_left_ff  <= has_left;
         s1_right_ff <= has_right;
         s1_last_ff  <= last;
         fwd_ff      <= s1_valid_ff && (s1_col_ff == in_col_ff);
         fwd_a_ff    <= col_b;
         fwd_b_ff    <= s1_pix_ff;
      end
   end

   assign col_a = fwd_ff ? fwd_a_ff : rd_a_ff;
   assign col_b = fwd_ff ? fwd_b_ff : rd_b_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         store_a[s1_col_ff] <= col_b;
         store_b[s1_col_ff] <= s1_pix_ff;
      end
   end

   // ---------------------------------------------------------------- window

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         pp_mid_ff <= p_mid_ff;
         p_up_ff   <= col_a;
         p_mid_ff  <= col_b;
         p_down_ff <= s1_pix_ff;
      end
   end

   always_comb begin
      border   = (mode_ff == lied_pkg::MODE_EXPAND) ? lied_pkg::WHITE_PIX : lied_pkg::BLACK_PIX;
      center   = p_mid_ff;
      nb_up    = s1_up_ff    ? p_up_ff   : border;
      nb_down  = s1_down_ff  ? p_down_ff : border;
      nb_left  = s1_left_ff  ? pp_mid_ff : border;
      nb_right = s1_right_ff ? col_b     : border;
      if (mode_ff == lied_pkg::MODE_CONTRACT) begin
         result = ((nb_up == center) && (nb_left == center) &&
                   (nb_down == center) && (nb_right == center)) ? center : lied_pkg::GRAY_PIX;
      end else if (center != lied_pkg::GRAY_PIX) begin
         result = center;
      end else if (nb_up != lied_pkg::GRAY_PIX) begin
         result = nb_up;
      end else if (nb_left != lied_pkg::GRAY_PIX) begin
         result = nb_left;
      end else if (nb_down != lied_pkg::GRAY_PIX) begin
         result = nb_down;
      end else if (nb_right != lied_pkg::GRAY_PIX) begin
         result = nb_right;
      end else begin
         result = lied_pkg::GRAY_PIX;
      end
   end

   assign push = '{valid: s1_valid_ff && s1_emit_ff,
                   word:  '{pix: result, last: s1_last_ff}};

   lied_out_fifo u_out_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .level  (level),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

// ===== rtl/core/lied_out_fifo.sv =====
// Result queue that decouples the window stage from the result receiver.
`default_nettype none

module lied_out_fifo (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lied_pkg::fifo_push_type              push,
   output      logic [lied_pkg::FIFO_LVL_BITS-1:0]    level,
   lied_rsp_if.source                                rsp_if
);

   lied_pkg::rsp_word_type entry_ff [lied_pkg::FIFO_DEPTH];

   logic [lied_pkg::FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lied_pkg::FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lied_pkg::FIFO_LVL_BITS-1:0] level_ff, level_in;
   logic                               pop;
   lied_pkg::rsp_word_type             head;

   assign pop  = rsp_if.valid && rsp_if.ready;
   assign head = entry_ff[rd_ptr_ff];

   assign rsp_if.valid      = (level_ff != '0);
   assign rsp_if.red_out    = head.pix.red;
   assign rsp_if.green_out  = head.pix.green;
   assign rsp_if.blue_out   = head.pix.blue;
   assign rsp_if.frame_last = head.last;
   assign level             = level_ff;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      case ({push.valid, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.word;
      end
   end

endmodule

`default_nettype wire
